### rtl/cae_pkg.sv
// Package for the PCI configuration access engine.
// Holds store sizing, the status codes, the decoded request type and lane helpers.
// No dependencies.
package cae_pkg;

  localparam int BUS_COUNT       = 2;
  localparam int DWORDS_PER_FUNC = 64;
  localparam int STORE_DEPTH     = BUS_COUNT * 32 * 8 * DWORDS_PER_FUNC;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int IDX_FULL_W      = 22;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NO_BUS  = 2'd2
  } status_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } clr_state_t;

  typedef struct packed {
    logic                is_write;
    logic                req_ok;
    logic                bus_ok;
    logic [STORE_AW-1:0] idx;
    logic [1:0]          lane;
    logic [2:0]          width;
    logic [31:0]         wdata;
    logic [31:0]         addr;
  } req_t;

  typedef struct packed {
    logic                active;
    logic [STORE_AW-1:0] idx;
  } clr_t;

  function automatic logic [31:0] lane_mask(input logic [2:0] width);
    logic [31:0] m;
    case (width)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

### rtl/cae_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cae_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/cae_clear.sv
// Post-reset sweep that fills the configuration store with all ones.
// Depends on cae_pkg.
module cae_clear (
  input  logic          clk,
  input  logic          rst_n,
  output cae_pkg::clr_t clr
);

  cae_pkg::clr_state_t            state_r, state_nxt;
  logic [cae_pkg::STORE_AW-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cae_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      cae_pkg::ST_CLEAR: begin
        if (cnt_r == cae_pkg::STORE_AW'(cae_pkg::STORE_DEPTH - 1)) begin
          state_nxt = cae_pkg::ST_RUN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cae_pkg::ST_RUN: begin
        state_nxt = cae_pkg::ST_RUN;
      end
      default: begin
        state_nxt = cae_pkg::ST_CLEAR;
      end
    endcase
  end

  assign clr.active = (state_r == cae_pkg::ST_CLEAR);
  assign clr.idx    = cnt_r;

endmodule

### rtl/cae_decode.sv
// Request checker: validates an access and forms the address word and store index.
// Depends on cae_pkg.
module cae_decode (
  input  logic          action,
  input  logic [15:0]   segment_number,
  input  logic [7:0]    bus_number,
  input  logic [7:0]    device_number,
  input  logic [7:0]    function_number,
  input  logic [7:0]    byte_offset,
  input  logic [2:0]    access_width,
  input  logic [31:0]   write_data,
  output cae_pkg::req_t req
);

  logic                          width_ok;
  logic                          in_space;
  logic [cae_pkg::IDX_FULL_W-1:0] idx_full;

  always_comb begin
    case (access_width)
      3'd1:    width_ok = 1'b1;
      3'd2:    width_ok = ~byte_offset[0];
      3'd4:    width_ok = (byte_offset[1:0] == 2'b00);
      default: width_ok = 1'b0;
    endcase
  end

  assign in_space = ({1'b0, byte_offset} + {6'd0, access_width}) <= 9'd256;
  assign idx_full = {bus_number, device_number[4:0], function_number[2:0], byte_offset[7:2]};

  assign req.is_write = action;
  assign req.req_ok   = (segment_number == 16'd0) && (device_number < 8'd32)
                     && (function_number < 8'd8) && width_ok && in_space;
  assign req.bus_ok   = {1'b0, bus_number} < 9'(cae_pkg::BUS_COUNT);
  assign req.idx      = idx_full[cae_pkg::STORE_AW-1:0];
  assign req.lane     = byte_offset[1:0];
  assign req.width    = access_width;
  assign req.wdata    = write_data;
  assign req.addr     = {1'b1, 7'd0, bus_number, device_number[4:0], function_number[2:0],
                         byte_offset[7:2], 2'b00};

endmodule

### rtl/pci_config_access_engine_top.sv
// Top level of the PCI configuration access engine (mechanism #1).
// Depends on cae_pkg, cae_decode, cae_clear and cae_ram.
//
// After reset the block sweeps its dword store to all ones, one dword per cycle, over all
// BUS_COUNT * 16384 dwords (32768 with two buses) while in_tready stays low. After that it
// takes one request per cycle while the output is not stalled. The store is read in the
// cycle of acceptance while the request is registered; the dword is then merged, written
// back and the result is placed in the output register, which drives out_tvalid. A write
// followed at once by a request to the same dword is served by forwarding, so back-to-back
// requests keep one request per cycle; a stalled output holds the request in flight.
module pci_config_access_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // segment_number, bus_number, device_number, function_number, byte_offset,
  // access_width, write_data, zero padding
  input  logic [87:0] in_tdata,
  // action
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data, address_word
  output logic [63:0] out_tdata,
  // status
  output logic [1:0]  out_tuser
);

  cae_pkg::req_t req_in;
  cae_pkg::req_t s1_r, s1_nxt;
  cae_pkg::clr_t clr;

  logic        busy_r, busy_nxt;
  logic        fwd_hit_r, fwd_hit_nxt;
  logic [31:0] fwd_data_r, fwd_data_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  logic        accept, finishing, wr_en;
  logic        ram_we, ram_re;
  logic [cae_pkg::STORE_AW-1:0] ram_waddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic [31:0] cur, mask, lane_m, merged, rd_val;
  logic [4:0]  shamt;

  cae_decode u_decode (
    .action          (in_tuser[0]),
    .segment_number  (in_tdata[15:0]),
    .bus_number      (in_tdata[23:16]),
    .device_number   (in_tdata[31:24]),
    .function_number (in_tdata[39:32]),
    .byte_offset     (in_tdata[47:40]),
    .access_width    (in_tdata[50:48]),
    .write_data      (in_tdata[82:51]),
    .req             (req_in)
  );

  cae_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  cae_ram #(
    .DEPTH (cae_pkg::STORE_DEPTH),
    .WIDTH (32)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (req_in.idx),
    .rdata (ram_rdata)
  );

  assign finishing = busy_r && (!out_valid_r || out_tready);
  assign in_tready = !clr.active && (!busy_r || finishing);
  assign accept    = in_tvalid && in_tready;

  assign cur    = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign shamt  = {s1_r.lane, 3'b000};
  assign mask   = cae_pkg::lane_mask(s1_r.width);
  assign lane_m = mask << shamt;
  assign merged = (s1_r.width == 3'd4) ? s1_r.wdata
                : ((cur & ~lane_m) | ((s1_r.wdata << shamt) & lane_m));
  assign rd_val = (cur >> shamt) & mask;

  assign wr_en     = finishing && s1_r.is_write && s1_r.req_ok && s1_r.bus_ok;
  assign ram_we    = clr.active || wr_en;
  assign ram_waddr = clr.active ? clr.idx : s1_r.idx;
  assign ram_wdata = clr.active ? 32'hffff_ffff : merged;
  assign ram_re    = accept && req_in.req_ok && req_in.bus_ok;

  always_comb begin
    busy_nxt      = busy_r;
    s1_nxt        = s1_r;
    fwd_hit_nxt   = fwd_hit_r;
    fwd_data_nxt  = fwd_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (finishing) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (!s1_r.req_ok) begin
        out_data_nxt = 64'd0;
        out_user_nxt = cae_pkg::STAT_INVALID;
      end else if (!s1_r.bus_ok) begin
        out_data_nxt = {s1_r.addr, (s1_r.is_write ? 32'd0 : mask)};
        out_user_nxt = cae_pkg::STAT_NO_BUS;
      end else begin
        out_data_nxt = {s1_r.addr, (s1_r.is_write ? 32'd0 : rd_val)};
        out_user_nxt = cae_pkg::STAT_OK;
      end
    end

    if (accept) begin
      busy_nxt     = 1'b1;
      s1_nxt       = req_in;
      fwd_hit_nxt  = wr_en && (s1_r.idx == req_in.idx);
      fwd_data_nxt = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/cae_checker.sv
// Port-level checker for the PCI configuration access engine, bound to the top level.
// Depends on cae_pkg and pci_config_access_engine_top.
module cae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == cae_pkg::STAT_INVALID) |-> (out_tdata == 64'd0))
    else $error("rejected request returned nonzero data");

  a_ok_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == cae_pkg::STAT_OK)
      |-> out_tdata[63] && ({1'b0, out_tdata[55:48]} < 9'(cae_pkg::BUS_COUNT)))
    else $error("accepted request has bad address word");

  a_nobus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == cae_pkg::STAT_NO_BUS)
      |-> out_tdata[63] && ({1'b0, out_tdata[55:48]} >= 9'(cae_pkg::BUS_COUNT)))
    else $error("missing-bus status on an implemented bus");

  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_tready && !out_tvalid)
    else $error("request taken during store clearing");

endmodule

bind pci_config_access_engine_top cae_checker u_cae_checker (.*);
